[rtl/core/dmtq_pkg.sv]
// ----------------------------------------------------------------------------
// dmtq_pkg
// Types and codes shared by the delayed message timer queue modules.
// ----------------------------------------------------------------------------
package dmtq_pkg;

  localparam logic [1:0] OP_SEND   = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_PURGE  = 2'd3;

  localparam logic [2:0] ST_DELIVERED = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_NONE_DUE  = 3'd5;

  localparam logic [1:0] RULE_WHOLE_MACHINE = 2'd0;
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam int unsigned MAX_OUT = 16;

  typedef struct packed {
    logic [31:0] etime;
    logic [15:0] name;
    logic [15:0] recv;
    logic [15:0] sender;
    logic [1:0]  rule;
    logic [7:0]  scope;
    logic [1:0]  queue;
    logic [1:0]  kind;
    logic        timer;
    logic [31:0] payload;
  } entry_t;

  typedef struct packed {
    logic dup;
    logic later;
    logic head_ok;
    logic due;
    logic rm_hit;
    logic purge_hit;
  } cmp_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] name;
    logic [15:0] recv;
    logic [15:0] sender;
    logic [1:0]  rule;
    logic [7:0]  scope;
    logic [1:0]  queue;
    logic [1:0]  kind;
    logic [31:0] value;
    logic        timer;
    logic        copy;
  } res_t;

endpackage

[rtl/core/dmtq_cmp.sv]
// ----------------------------------------------------------------------------
// dmtq_cmp
// Shared compare unit: matches one stored entry against the request key.
// ----------------------------------------------------------------------------
module dmtq_cmp
  import dmtq_pkg::*;
(
  input  entry_t      entry_i,
  input  entry_t      key_i,
  input  logic [31:0] now_i,
  output cmp_t        cmp_o
);

  logic ids_eq;

  assign ids_eq = (entry_i.name == key_i.name) && (entry_i.recv == key_i.recv) &&
                  (entry_i.sender == key_i.sender);

  always_comb begin
    cmp_o.dup = ids_eq && (entry_i.rule == key_i.rule) && (entry_i.scope == key_i.scope) &&
                (entry_i.queue == key_i.queue) && (entry_i.kind == key_i.kind) &&
                (entry_i.timer == key_i.timer) && (entry_i.etime == key_i.etime) &&
                ((key_i.kind == KIND_NONE) || (entry_i.payload == key_i.payload));
    cmp_o.later     = entry_i.etime > key_i.etime;
    cmp_o.head_ok   = key_i.etime <= entry_i.etime;
    cmp_o.due       = entry_i.etime <= now_i;
    cmp_o.rm_hit    = ids_eq && (entry_i.timer == key_i.timer);
    cmp_o.purge_hit = (entry_i.recv == key_i.recv) && (entry_i.rule != RULE_WHOLE_MACHINE);
  end

endmodule

[rtl/core/delayed_message_timer_queue_unit.sv]
// ----------------------------------------------------------------------------
// delayed_message_timer_queue_unit
// Time-sorted store of delayed messages with a tick counter.
// ----------------------------------------------------------------------------
// Requests come in on the s_axis channel (tuser = opcode, tdata = message),
// results leave on the m_axis channel (tuser = status, tdata = message or
// removal count, tlast on the final result of a request).
// One request is handled at a time; s_axis_tready_o is high only while the
// sequencer is idle. The entries live in a memory with one read and one
// write port and are read one entry at a time by one shared compare unit.
// A send with zero delay is delivered without touching the store. A send
// with delay scans the store for a duplicate and the insert point, then
// shifts the later entries up one place and writes the new one; it is
// dropped without storing when it is a duplicate or the store is full.
// Tick, remove and purge each make one compacting pass over the store.
// A tick emits up to 16 due entries in time order while it compacts the
// store. Results sit in one output register; when the receiver stalls the
// sequencer waits at its next result. Reset empties the store and clears
// the tick counter at once, with no clearing pass.
// ----------------------------------------------------------------------------
module delayed_message_timer_queue_unit
  import dmtq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // delay, name, receiver, sender, rule, scope, queue_sel,
  // data_kind, data_value, timer_flag, cc_flag
  input  logic [111:0] s_axis_tdata_i,
  // opcode
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_name, out_receiver, out_sender, out_rule, out_scope, out_queue,
  // out_kind, out_value, out_timer, out_copy
  output logic [95:0]  m_axis_tdata_o,
  // status
  output logic [2:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD  = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SEV  = 4'd3;
  localparam logic [3:0] S_SHRD = 4'd4;
  localparam logic [3:0] S_SHWR = 4'd5;
  localparam logic [3:0] S_INS  = 4'd6;
  localparam logic [3:0] S_CRD  = 4'd7;
  localparam logic [3:0] S_CEV  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  entry_t mem [DEPTH];
  entry_t rd_q;

  logic [3:0]    state_q, state_d;
  logic [1:0]    op_q, op_d;
  entry_t        key_q, key_d;
  logic [15:0]   delay_q, delay_d;
  logic [31:0]   now_q, now_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          found_q, found_d;
  logic          dup_q, dup_d;
  logic [4:0]    n_q, n_d;
  logic          pend_v_q, pend_v_d;
  entry_t        pend_q, pend_d;
  res_t          res_q, res_d;
  logic          ov_q, ov_d;
  res_t          od_q, od_d;
  logic          olast_q, olast_d;

  logic          we;
  logic [IW-1:0] wa;
  entry_t        wd;
  logic [IW-1:0] ra;
  cmp_t          cmp;
  entry_t        in_e;
  logic          can_push;
  logic          push;
  res_t          push_res;
  logic          push_last;
  logic [32:0]   sum;
  logic          hit;
  logic [CW-1:0] idx_m1;

  dmtq_cmp u_cmp (
    .entry_i (rd_q),
    .key_i   (key_q),
    .now_i   (now_q),
    .cmp_o   (cmp)
  );

  assign in_e.etime   = '0;
  assign in_e.name    = s_axis_tdata_i[31:16];
  assign in_e.recv    = s_axis_tdata_i[47:32];
  assign in_e.sender  = s_axis_tdata_i[63:48];
  assign in_e.rule    = s_axis_tdata_i[65:64];
  assign in_e.scope   = s_axis_tdata_i[73:66];
  assign in_e.queue   = s_axis_tdata_i[75:74];
  assign in_e.kind    = s_axis_tdata_i[77:76];
  assign in_e.payload = s_axis_tdata_i[109:78];
  assign in_e.timer   = s_axis_tdata_i[110];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign can_push = !ov_q || m_axis_tready_i;
  assign sum      = {1'b0, now_q} + {17'd0, delay_q};
  assign idx_m1   = idx_q - CW'(1);

  function automatic res_t entry_res(entry_t e);
    res_t r;
    r.status = ST_DELIVERED;
    r.name   = e.name;
    r.recv   = e.recv;
    r.sender = e.sender;
    r.rule   = e.rule;
    r.scope  = e.scope;
    r.queue  = e.queue;
    r.kind   = e.kind;
    r.value  = e.payload;
    r.timer  = e.timer;
    r.copy   = 1'b0;
    return r;
  endfunction

  function automatic res_t status_res(logic [2:0] st, logic [31:0] v);
    res_t r;
    r        = '0;
    r.status = st;
    r.value  = v;
    return r;
  endfunction

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    delay_d   = delay_q;
    now_d     = now_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    wr_d      = wr_q;
    pos_d     = pos_q;
    found_d   = found_q;
    dup_d     = dup_q;
    n_d       = n_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    res_d     = res_q;
    we        = 1'b0;
    wa        = idx_q[IW-1:0];
    wd        = rd_q;
    ra        = idx_q[IW-1:0];
    push      = 1'b0;
    push_res  = res_q;
    push_last = 1'b1;
    hit       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = s_axis_tuser_i;
          key_d    = in_e;
          delay_d  = s_axis_tdata_i[15:0];
          idx_d    = '0;
          wr_d     = '0;
          n_d      = '0;
          pend_v_d = 1'b0;
          priority case (s_axis_tuser_i)
            OP_SEND: begin
              if (s_axis_tdata_i[15:0] == 16'd0) begin
                res_d      = entry_res(in_e);
                res_d.copy = s_axis_tdata_i[111];
                state_d    = S_FIN;
              end else begin
                state_d = S_ADD;
              end
            end
            OP_TICK: begin
              if (now_q != 32'hFFFF_FFFF) now_d = now_q + 32'd1;
              state_d = S_CRD;
            end
            default: state_d = S_CRD;
          endcase
        end
      end
      S_ADD: begin
        key_d.etime = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        dup_d       = 1'b0;
        found_d     = 1'b0;
        pos_d       = cnt_q;
        state_d     = S_SRD;
      end
      S_SRD: begin
        if (idx_q == cnt_q) begin
          if (dup_q) begin
            res_d   = status_res(ST_DUPLICATE, 32'd0);
            state_d = S_FIN;
          end else if (cnt_q == CW'(DEPTH)) begin
            res_d   = status_res(ST_FULL, 32'd0);
            state_d = S_FIN;
          end else begin
            state_d = S_SHRD;
          end
        end else begin
          state_d = S_SEV;
        end
      end
      S_SEV: begin
        if (cmp.dup) dup_d = 1'b1;
        if (!found_q) begin
          if (idx_q == '0) begin
            if (cmp.head_ok) begin
              pos_d   = '0;
              found_d = 1'b1;
            end
          end else if (cmp.later) begin
            pos_d   = idx_q;
            found_d = 1'b1;
          end
        end
        idx_d   = idx_q + CW'(1);
        state_d = S_SRD;
      end
      S_SHRD: begin
        // move entries up one place, from the top down to the insert point
        ra = idx_m1[IW-1:0];
        if (idx_q == pos_q) state_d = S_INS;
        else state_d = S_SHWR;
      end
      S_SHWR: begin
        we      = 1'b1;
        wa      = idx_q[IW-1:0];
        idx_d   = idx_m1;
        state_d = S_SHRD;
      end
      S_INS: begin
        we      = 1'b1;
        wa      = pos_q[IW-1:0];
        wd      = key_q;
        cnt_d   = cnt_q + CW'(1);
        res_d   = status_res(ST_QUEUED, 32'd0);
        state_d = S_FIN;
      end
      S_CRD: begin
        if (idx_q == cnt_q) begin
          cnt_d = wr_q;
          if (op_q == OP_TICK) begin
            if (pend_v_q) res_d = entry_res(pend_q);
            else res_d = status_res(ST_NONE_DUE, 32'd0);
          end else begin
            res_d = status_res(ST_REMOVED, 32'(cnt_q - wr_q));
          end
          state_d = S_FIN;
        end else begin
          state_d = S_CEV;
        end
      end
      S_CEV: begin
        priority case (op_q)
          OP_TICK:   hit = cmp.due && (n_q < 5'(MAX_OUT));
          OP_REMOVE: hit = cmp.rm_hit;
          default:   hit = cmp.purge_hit;
        endcase
        if (!hit) begin
          we      = 1'b1;
          wa      = wr_q[IW-1:0];
          wr_d    = wr_q + CW'(1);
          idx_d   = idx_q + CW'(1);
          state_d = S_CRD;
        end else if (op_q != OP_TICK) begin
          idx_d   = idx_q + CW'(1);
          state_d = S_CRD;
        end else if (!pend_v_q || can_push) begin
          // the held due entry goes out once the next one is known
          push      = pend_v_q;
          push_res  = entry_res(pend_q);
          push_last = 1'b0;
          pend_d    = rd_q;
          pend_v_d  = 1'b1;
          n_d       = n_q + 5'd1;
          idx_d     = idx_q + CW'(1);
          state_d   = S_CRD;
        end
      end
      S_FIN: begin
        if (can_push) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d    = ov_q;
    od_d    = od_q;
    olast_d = olast_q;
    if (m_axis_tready_i) ov_d = 1'b0;
    if (push) begin
      ov_d    = 1'b1;
      od_d    = push_res;
      olast_d = push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      now_q    <= '0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      now_q    <= now_d;
      cnt_q    <= cnt_d;
      ov_q     <= ov_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    delay_q <= delay_d;
    idx_q   <= idx_d;
    wr_q    <= wr_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    dup_q   <= dup_d;
    n_q     <= n_d;
    pend_q  <= pend_d;
    res_q   <= res_d;
    od_q    <= od_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o  = od_q.status;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {od_q.copy, od_q.timer, od_q.value, od_q.kind, od_q.queue,
                            od_q.scope, od_q.rule, od_q.sender, od_q.recv, od_q.name};

endmodule
